[hdl/pss_pkg.sv]
// Package: shared constants, types and sine table for the particle state stepper.
`timescale 1ns / 1ps

package pss_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_QN         = 1 << (SINE_TABLE_BITS - 2);
    localparam int SINE_IDX_W      = SINE_TABLE_BITS - 2;

    // one restoring-division bit per stage over the 48-bit dividend age << 16
    localparam int DIV_STAGES = 48;
    localparam int AGE_W      = 32;
    localparam int POST_STAGES = 4;
    localparam int LAST_STAGE = DIV_STAGES + POST_STAGES;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [31:0] TIME_ONE = 32'd65536;

    // register indexes
    localparam logic [2:0] CFG_SIZE_MODE  = 3'd0;
    localparam logic [2:0] CFG_GRAVITY    = 3'd1;
    localparam logic [2:0] CFG_SIZE_CYCLE = 3'd2;
    localparam logic [2:0] CFG_PAGE_COUNT = 3'd3;
    localparam logic [2:0] CFG_PAGE_TIME  = 3'd4;

    // size modes
    localparam logic [2:0] MODE_CONST  = 3'd0;
    localparam logic [2:0] MODE_LINEAR = 3'd1;
    localparam logic [2:0] MODE_SAW    = 3'd2;
    localparam logic [2:0] MODE_TRI    = 3'd3;
    localparam logic [2:0] MODE_PULSE  = 3'd4;

    typedef logic [16:0] t_sine_lut [0:SINE_QN-1];

    typedef struct packed {
        logic [31:0]        step_time;
        logic [31:0]        age;
        logic signed [31:0] life;
        logic [59:0]        pos;
        logic [59:0]        vel;
        logic signed [19:0] ang;
        logic signed [19:0] rate;
        logic [63:0]        size_range;
        // division state
        logic [31:0]        abits;
        logic [31:0]        srem;
        logic [16:0]        dq;
        logic               dhi;
        logic [31:0]        prem;
        logic [7:0]         pm;
        // post-division work
        logic [2:0][52:0]   gt;
        logic [52:0]        rt;
        logic signed [17:0] tf;
        logic [31:0]        nage;
        logic [31:0]        nlife;
        logic [31:0]        blend;
        logic [7:0]         npm;
        logic [59:0]        nvel;
        logic [19:0]        nang;
        logic [33:0]        wp;
        logic [33:0]        hp;
        logic [2:0][52:0]   vt;
        logic [15:0]        w;
        logic [15:0]        h;
        logic [59:0]        npos;
    } t_item;

    // quarter-wave sine, odd degree-9 polynomial, truncating Horner steps
    function automatic t_sine_lut build_sine();
        t_sine_lut   lut;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        for (int n = 0; n < SINE_QN; n++) begin
            x  = 64'(n) << (18 - SINE_TABLE_BITS);
            x2 = (x * x) >> 16;
            t  = 64'd11;
            t  = 64'd307    - ((x2 * t) >> 16);
            t  = 64'd5223   - ((x2 * t) >> 16);
            t  = 64'd42334  - ((x2 * t) >> 16);
            t  = 64'd102944 - ((x2 * t) >> 16);
            t  = (x * t) >> 16;
            lut[n] = (t > 64'd65536) ? ONE_Q16 : t[16:0];
        end
        return lut;
    endfunction

    localparam t_sine_lut SINE_LUT = build_sine();

endpackage

[hdl/pss_in_if.sv]
// Interface: input channel carrying one particle record per beat.
`timescale 1ns / 1ps

interface pss_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        step_time;
    logic [31:0]        age;
    logic signed [31:0] life_left;
    logic [59:0]        position_xyz;
    logic [59:0]        velocity_xyz;
    logic signed [19:0] spin_angle;
    logic signed [19:0] spin_rate;
    logic [63:0]        size_range;

    modport source (output valid, step_time, age, life_left, position_xyz, velocity_xyz,
                    spin_angle, spin_rate, size_range, input ready);
    modport sink   (input valid, step_time, age, life_left, position_xyz, velocity_xyz,
                    spin_angle, spin_rate, size_range, output ready);
endinterface

[hdl/pss_out_if.sv]
// Interface: output channel carrying one updated particle per beat.
`timescale 1ns / 1ps

interface pss_out_if;
    logic               valid;
    logic               ready;
    logic               alive;
    logic [59:0]        new_position_xyz;
    logic [59:0]        new_velocity_xyz;
    logic signed [19:0] new_spin_angle;
    logic [31:0]        new_age;
    logic signed [31:0] new_life_left;
    logic               size_valid;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic [7:0]         page;
    logic [7:0]         next_page;
    logic signed [31:0] page_blend;

    modport source (output valid, alive, new_position_xyz, new_velocity_xyz, new_spin_angle,
                    new_age, new_life_left, size_valid, width, height, page, next_page,
                    page_blend, input ready);
    modport sink   (input valid, alive, new_position_xyz, new_velocity_xyz, new_spin_angle,
                    new_age, new_life_left, size_valid, width, height, page, next_page,
                    page_blend, output ready);
endinterface

[hdl/particle_state_stepper.sv]
// Top level: pipelined Euler update of particle records with size and flipbook page.
// Throughput: one beat per cycle unless the output beat waits; 48 restoring-division
// stages (one quotient bit each) followed by four arithmetic stages set the depth.
// The whole pipe advances together and holds while the output beat waits.
// Reset (synchronous, active low) clears the valid bits and restores register defaults.
`timescale 1ns / 1ps

module particle_state_stepper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [59:0]       i_cfg_data,
    pss_in_if.sink            i_in,
    pss_out_if.source         o_out
);

    // ---------------------------------------------------------------
    // Configuration registers, to be written by the user only while the pipe is idle (not enforced)
    // ---------------------------------------------------------------
    logic [2:0]  r_size_mode;
    logic [59:0] r_gravity;
    logic [31:0] r_size_cycle;
    logic [7:0]  r_page_count;
    logic [31:0] r_page_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_mode  <= pss_pkg::MODE_LINEAR;
            r_gravity    <= '0;
            r_size_cycle <= pss_pkg::TIME_ONE;
            r_page_count <= 8'd1;
            r_page_time  <= pss_pkg::TIME_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pss_pkg::CFG_SIZE_MODE:  r_size_mode  <= i_cfg_data[2:0];
                pss_pkg::CFG_GRAVITY:    r_gravity    <= i_cfg_data;
                pss_pkg::CFG_SIZE_CYCLE: r_size_cycle <= i_cfg_data[31:0];
                pss_pkg::CFG_PAGE_COUNT: r_page_count <= i_cfg_data[7:0];
                pss_pkg::CFG_PAGE_TIME:  r_page_time  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // zero divisors behave as the smallest step / a single page
    logic [31:0] w_ct;
    logic [31:0] w_pt;
    logic [7:0]  w_pc;
    assign w_ct = (r_size_cycle == '0) ? 32'd1 : r_size_cycle;
    assign w_pt = (r_page_time == '0) ? 32'd1 : r_page_time;
    assign w_pc = (r_page_count == '0) ? 8'd1 : r_page_count;

    // ---------------------------------------------------------------
    // Arithmetic helpers
    // ---------------------------------------------------------------
    // signed Q10.10 times unsigned Q16.16, exact
    function automatic logic [52:0] mul53(logic [19:0] a, logic [31:0] b);
        return $signed({{33{a[19]}}, a}) * $signed({21'd0, b});
    endfunction

    // round to nearest, ties up, drop 16 fraction bits; 38-bit signed result
    function automatic logic [37:0] rnd53(logic [52:0] p);
        logic [52:0] t;
        t = p + 53'd32768;
        return {t[52], t[52:16]};
    endfunction

    function automatic logic [19:0] rnd34(logic [33:0] p);
        logic [33:0] t;
        t = p + 34'd32768;
        return {{2{t[33]}}, t[33:16]};
    endfunction

    function automatic logic [19:0] sat20(logic signed [37:0] v);
        if (v > 38'sd524287)
            return 20'h7FFFF;
        else if (v < -38'sd524288)
            return 20'h80000;
        else
            return v[19:0];
    endfunction

    function automatic logic [15:0] sat16(logic signed [19:0] v);
        if (v > 20'sd32767)
            return 16'h7FFF;
        else if (v < -20'sd32768)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    // component plus rounded product, saturated to Q10.10
    function automatic logic [19:0] add_rnd(logic [19:0] c, logic [52:0] p);
        return sat20($signed({{18{c[19]}}, c}) + $signed(rnd53(p)));
    endfunction

    // one restoring-division step for the size quotient; stages below 32 also
    // run the page division and fold its quotient bits into a running mod
    function automatic pss_pkg::t_item div_step(pss_pkg::t_item x, int k);
        pss_pkg::t_item y;
        logic [32:0]    sr;
        logic [32:0]    pr;
        logic [8:0]     pm;
        logic           qb;
        logic           pb;
        y  = x;
        sr = {x.srem, x.abits[31]};
        qb = (sr >= {1'b0, w_ct});
        if (qb)
            sr = sr - {1'b0, w_ct};
        y.srem = sr[31:0];
        y.dq   = {x.dq[15:0], qb};
        y.dhi  = x.dhi | x.dq[16];
        if (k < pss_pkg::AGE_W) begin
            pr = {x.prem, x.abits[31]};
            pb = (pr >= {1'b0, w_pt});
            if (pb)
                pr = pr - {1'b0, w_pt};
            y.prem = pr[31:0];
            pm = {x.pm, pb};
            if (pm >= {1'b0, w_pc})
                pm = pm - {1'b0, w_pc};
            y.pm = pm[7:0];
        end
        y.abits = {x.abits[30:0], 1'b0};
        return y;
    endfunction

    // ---------------------------------------------------------------
    // Pipeline control: one global advance, the output stage is the skid
    // ---------------------------------------------------------------
    logic [pss_pkg::LAST_STAGE:0] r_v;
    logic                         w_adv;

    assign w_adv       = !r_v[pss_pkg::LAST_STAGE] || o_out.ready;
    assign i_in.ready  = w_adv;
    assign o_out.valid = r_v[pss_pkg::LAST_STAGE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[pss_pkg::LAST_STAGE-1:0], i_in.valid};
        end
    end

    // ---------------------------------------------------------------
    // Payload stages
    // ---------------------------------------------------------------
    pss_pkg::t_item r_st [0:pss_pkg::DIV_STAGES];
    pss_pkg::t_item r_p1, r_p2, r_p3, r_p4;
    pss_pkg::t_item n_s0, n_p1, n_p2, n_p3, n_p4;

    // capture beat, prime division state
    always_comb begin
        n_s0            = '0;
        n_s0.step_time  = i_in.step_time;
        n_s0.age        = i_in.age;
        n_s0.life       = i_in.life_left;
        n_s0.pos        = i_in.position_xyz;
        n_s0.vel        = i_in.velocity_xyz;
        n_s0.ang        = i_in.spin_angle;
        n_s0.rate       = i_in.spin_rate;
        n_s0.size_range = i_in.size_range;
        n_s0.abits      = i_in.age;
    end

    // P1: gravity and spin products, size factor, age, life, page terms
    logic [pss_pkg::SINE_TABLE_BITS-1:0] w_k;
    logic [1:0]                          w_quad;
    logic [pss_pkg::SINE_IDX_W-1:0]      w_r;
    logic [pss_pkg::SINE_IDX_W:0]        w_x;
    logic [16:0]                         w_s;
    logic [16:0]                         w_f;
    logic [32:0]                         w_age_sum;
    logic signed [33:0]                  w_life_d;
    logic signed [33:0]                  w_blend_d;
    logic [8:0]                          w_pg1;

    always_comb begin
        pss_pkg::t_item s;
        s    = r_st[pss_pkg::DIV_STAGES];
        n_p1 = s;
        for (int c = 0; c < 3; c++)
            n_p1.gt[c] = mul53(r_gravity[20*c +: 20], s.step_time);
        n_p1.rt = mul53(s.rate, s.step_time);

        // sine pulse: phase is quotient bits 16..1, table index its top bits
        w_k    = s.dq[16 -: pss_pkg::SINE_TABLE_BITS];
        w_quad = w_k[pss_pkg::SINE_TABLE_BITS-1 -: 2];
        w_r    = w_k[pss_pkg::SINE_IDX_W-1:0];
        w_x    = w_quad[0] ? ((pss_pkg::SINE_IDX_W+1)'(pss_pkg::SINE_QN) - {1'b0, w_r})
                           : {1'b0, w_r};
        w_s    = w_x[pss_pkg::SINE_IDX_W] ? pss_pkg::ONE_Q16
                                          : pss_pkg::SINE_LUT[w_x[pss_pkg::SINE_IDX_W-1:0]];
        w_f    = {1'b0, s.dq[15:0]};
        if (s.dq[15])
            w_f = pss_pkg::ONE_Q16 - w_f;

        case (r_size_mode)
            pss_pkg::MODE_LINEAR:
                n_p1.tf = (s.dhi || (s.dq[16] && (s.dq[15:0] != '0)))
                        ? {1'b0, pss_pkg::ONE_Q16} : {1'b0, s.dq};
            pss_pkg::MODE_SAW:   n_p1.tf = {2'b00, s.dq[15:0]};
            pss_pkg::MODE_TRI:   n_p1.tf = {w_f, 1'b0};
            pss_pkg::MODE_PULSE:
                n_p1.tf = w_quad[1] ? (18'sd32768 - $signed({1'b0, w_s}))
                                    : (18'sd32768 + $signed({1'b0, w_s}));
            default:             n_p1.tf = '0;
        endcase

        w_age_sum = {1'b0, s.age} + {1'b0, s.step_time};
        n_p1.nage = w_age_sum[32] ? 32'hFFFF_FFFF : w_age_sum[31:0];

        w_life_d   = $signed({{2{s.life[31]}}, s.life}) - $signed({2'b00, s.step_time});
        n_p1.nlife = (w_life_d < -34'sd2147483648) ? 32'h8000_0000 : w_life_d[31:0];

        w_blend_d  = 34'sd65536 - $signed({2'b00, s.prem});
        n_p1.blend = (w_blend_d < -34'sd2147483648) ? 32'h8000_0000 : w_blend_d[31:0];

        w_pg1    = {1'b0, s.pm} + 9'd1;
        n_p1.npm = (w_pg1 == {1'b0, w_pc}) ? 8'd0 : w_pg1[7:0];
    end

    // P2: new velocity and angle, size span products
    always_comb begin
        n_p2 = r_p1;
        for (int c = 0; c < 3; c++)
            n_p2.nvel[20*c +: 20] = add_rnd(r_p1.vel[20*c +: 20], r_p1.gt[c]);
        n_p2.nang = add_rnd(r_p1.ang, r_p1.rt);
        n_p2.wp = $signed({{18{r_p1.size_range[31]}}, r_p1.size_range[31:16]})
                * $signed({{16{r_p1.tf[17]}}, r_p1.tf});
        n_p2.hp = $signed({{18{r_p1.size_range[63]}}, r_p1.size_range[63:48]})
                * $signed({{16{r_p1.tf[17]}}, r_p1.tf});
    end

    // P3: displacement products with the new velocity, final width and height
    always_comb begin
        n_p3 = r_p2;
        for (int c = 0; c < 3; c++)
            n_p3.vt[c] = mul53(r_p2.nvel[20*c +: 20], r_p2.step_time);
        n_p3.w = sat16($signed({{4{r_p2.size_range[15]}}, r_p2.size_range[15:0]})
                     + $signed(rnd34(r_p2.wp)));
        n_p3.h = sat16($signed({{4{r_p2.size_range[47]}}, r_p2.size_range[47:32]})
                     + $signed(rnd34(r_p2.hp)));
    end

    // P4: new position
    always_comb begin
        n_p4 = r_p3;
        for (int c = 0; c < 3; c++)
            n_p4.npos[20*c +: 20] = add_rnd(r_p3.pos[20*c +: 20], r_p3.vt[c]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0] <= n_s0;
            for (int k = 0; k < pss_pkg::DIV_STAGES; k++)
                r_st[k+1] <= div_step(r_st[k], k);
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
            r_p4 <= n_p4;
        end
    end

    // ---------------------------------------------------------------
    // Output beat: dead particles pass through, derived fields zero
    // ---------------------------------------------------------------
    logic w_alive;
    logic w_size_on;
    assign w_alive   = (r_p4.life > 32'sd0);
    assign w_size_on = (r_size_mode == pss_pkg::MODE_LINEAR) || (r_size_mode == pss_pkg::MODE_SAW)
                    || (r_size_mode == pss_pkg::MODE_TRI) || (r_size_mode == pss_pkg::MODE_PULSE);

    assign o_out.alive            = w_alive;
    assign o_out.new_position_xyz = w_alive ? r_p4.npos : r_p4.pos;
    assign o_out.new_velocity_xyz = w_alive ? r_p4.nvel : r_p4.vel;
    assign o_out.new_spin_angle   = w_alive ? r_p4.nang : r_p4.ang;
    assign o_out.new_age          = w_alive ? r_p4.nage : r_p4.age;
    assign o_out.new_life_left    = w_alive ? r_p4.nlife : r_p4.life;
    assign o_out.size_valid       = w_alive && w_size_on;
    assign o_out.width            = (w_alive && w_size_on) ? r_p4.w : 16'd0;
    assign o_out.height           = (w_alive && w_size_on) ? r_p4.h : 16'd0;
    assign o_out.page             = w_alive ? r_p4.pm : 8'd0;
    assign o_out.next_page        = w_alive ? r_p4.npm : 8'd0;
    assign o_out.page_blend       = w_alive ? r_p4.blend : 32'd0;

endmodule

[tb/tb_particle_state_stepper.sv]
// Testbench: particle state stepper checked beat by beat against an in-bench predictor.
`timescale 1ns / 1ps

module tb_particle_state_stepper;

    localparam int LATENCY    = 52;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 200;

    // one particle record as offered to the block
    typedef struct {
        logic [31:0] step_time;
        logic [31:0] age;
        logic [31:0] life_left;
        logic [59:0] pos;
        logic [59:0] vel;
        logic [19:0] ang;
        logic [19:0] rate;
        logic [63:0] size_range;
    } t_particle;

    // the updated particle as the block should return it
    typedef struct {
        logic        alive;
        logic [59:0] pos;
        logic [59:0] vel;
        logic [19:0] ang;
        logic [31:0] age;
        logic [31:0] life;
        logic        size_valid;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  page;
        logic [7:0]  next_page;
        logic [31:0] blend;
    } t_update;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [59:0] cfg_data;

    pss_in_if  in_ch ();
    pss_out_if out_ch ();

    particle_state_stepper i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // predictor's copy of the registers
    logic [2:0]  m_size_mode;
    logic [59:0] exp_gravity;
    logic [31:0] m_cycle_time;
    logic [7:0]  m_page_count;
    logic [31:0] m_page_time;

    t_particle particle_q[$];
    t_update   update_q[$];

    int  n_errors;
    int  n_sent;
    int  n_seen;
    int  n_dead;
    int  idle_cycles;
    bit  timed_out;
    bit  quiet_phase;    // no idling on either side
    bit  hold_request;   // asks the sink to back off for a long stretch
    bit  in_taken;       // input beat accepted at the last rising edge
    int  hold_count;
    int  mode_hits[8];

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // fixed-point helpers
    // ---------------------------------------------------------------------
    function automatic longint sx(logic [63:0] v, int bits);
        logic [63:0] s;
        s = 64'd1 << (bits - 1);
        v = v & ((s << 1) - 64'd1);
        return longint'(v ^ s) - longint'(s);
    endfunction

    // round a Q16 product to nearest, ties up, via arithmetic shift
    function automatic longint rnd16(longint p);
        return (p + 32768) >>> 16;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // sin(pi/2 * x), x in Q16 over [0, 1.0]
    function automatic longint quarter_wave(longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 16;
        t = 11;
        t = 307 - ((x2 * t) >> 16);
        t = 5223 - ((x2 * t) >> 16);
        t = 42334 - ((x2 * t) >> 16);
        t = 102944 - ((x2 * t) >> 16);
        t = (x * t) >> 16;
        return t > 65536 ? 65536 : longint'(t);
    endfunction

    // sin(pi * tf) through the truncated table phase
    function automatic longint pulse_sine(longint unsigned tf);
        longint unsigned f;
        longint unsigned k;
        longint unsigned quad;
        longint unsigned qn;
        longint unsigned r;
        longint unsigned x;
        longint s;
        f    = (tf >> 1) & 64'hFFFF;
        k    = f >> (16 - pss_pkg::SINE_TABLE_BITS);
        quad = (k >> (pss_pkg::SINE_TABLE_BITS - 2)) & 3;
        qn   = 64'd1 << (pss_pkg::SINE_TABLE_BITS - 2);
        r    = k & (qn - 1);
        x    = quad[0] ? (qn - r) : r;
        s    = quarter_wave(x << (18 - pss_pkg::SINE_TABLE_BITS));
        return quad[1] ? -s : s;
    endfunction

    // one Euler step of a particle under the current registers
    function automatic t_update step_particle(t_particle p);
        t_update u;
        longint  t;
        longint  g;
        longint  v;
        longint  q;
        longint  tf;
        longint unsigned ct;
        longint unsigned pt;
        longint unsigned pc;
        longint unsigned qq;
        longint unsigned pg;
        longint  a;
        u = '{default: '0};
        t = longint'(p.step_time);
        if (sx(64'(p.life_left), 32) <= 0) begin
            u.pos  = p.pos;
            u.vel  = p.vel;
            u.ang  = p.ang;
            u.age  = p.age;
            u.life = p.life_left;
            return u;
        end
        u.alive = 1'b1;
        for (int i = 0; i < 3; i++) begin
            g = sx(64'(exp_gravity >> (20 * i)), 20);
            v = clip(sx(64'(p.vel >> (20 * i)), 20) + rnd16(g * t), 20);
            q = clip(sx(64'(p.pos >> (20 * i)), 20) + rnd16(v * t), 20);
            u.vel[20*i +: 20] = v[19:0];
            u.pos[20*i +: 20] = q[19:0];
        end
        v     = clip(sx(64'(p.ang), 20) + rnd16(sx(64'(p.rate), 20) * t), 20);
        u.ang = v[19:0];
        a     = longint'(p.age) + t;
        u.age = a > 64'hFFFFFFFF ? 32'hFFFFFFFF : a[31:0];
        a     = clip(sx(64'(p.life_left), 32) - t, 32);
        u.life = a[31:0];

        if (m_size_mode inside {pss_pkg::MODE_LINEAR, pss_pkg::MODE_SAW,
                                pss_pkg::MODE_TRI, pss_pkg::MODE_PULSE}) begin
            ct = m_cycle_time == 0 ? 1 : m_cycle_time;
            qq = (longint'(p.age) << 16) / ct;
            case (m_size_mode)
                pss_pkg::MODE_LINEAR: tf = qq > 65536 ? 65536 : longint'(qq);
                pss_pkg::MODE_SAW:    tf = longint'(qq & 64'hFFFF);
                pss_pkg::MODE_TRI: begin
                    tf = longint'(qq & 64'hFFFF);
                    if (tf >= 32768) tf = 65536 - tf;
                    tf = 2 * tf;
                end
                default:     tf = pulse_sine(qq) + 32768;
            endcase
            u.size_valid = 1'b1;
            v = clip(sx(p.size_range, 16) + rnd16(sx(p.size_range >> 16, 16) * tf), 16);
            u.width = v[15:0];
            v = clip(sx(p.size_range >> 32, 16) + rnd16(sx(p.size_range >> 48, 16) * tf), 16);
            u.height = v[15:0];
        end

        pt = m_page_time == 0 ? 1 : m_page_time;
        pc = m_page_count == 0 ? 1 : m_page_count;
        pg = (longint'(p.age) / pt) % pc;
        u.page      = pg[7:0];
        pg          = (pg + 1) % pc;
        u.next_page = pg[7:0];
        a           = clip(65536 - longint'(longint'(p.age) % pt), 32);
        u.blend     = a[31:0];
        return u;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // ---------------------------------------------------------------------
    // driver: one beat from the queue, held until the block takes it
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            // the beat on the bus (if any) was taken at the last rising edge
            if (particle_q.size() > 0 && (quiet_phase || $urandom_range(99) >= 6)) begin
                t_particle p;
                p = particle_q.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.step_time    <= p.step_time;
                in_ch.age          <= p.age;
                in_ch.life_left    <= p.life_left;
                in_ch.position_xyz <= p.pos;
                in_ch.velocity_xyz <= p.vel;
                in_ch.spin_angle   <= p.ang;
                in_ch.spin_rate    <= p.rate;
                in_ch.size_range   <= p.size_range;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // prediction happens when the block accepts the input beat
    always @(posedge i_clk) begin
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            t_particle p;
            p.step_time  = in_ch.step_time;
            p.age        = in_ch.age;
            p.life_left  = in_ch.life_left;
            p.pos        = in_ch.position_xyz;
            p.vel        = in_ch.velocity_xyz;
            p.ang        = in_ch.spin_angle;
            p.rate       = in_ch.spin_rate;
            p.size_range = in_ch.size_range;
            update_q.push_back(step_particle(p));
            n_sent++;
            if (p.life_left[31] || p.life_left == 0) n_dead++;
            else mode_hits[m_size_mode]++;
        end
    end

    // sink ready: random stalls, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_count   <= 0;
        end else if (hold_request && hold_count < HOLD_CYCLES) begin
            out_ch.ready <= 1'b0;
            hold_count   <= hold_count + 1;
        end else begin
            if (!hold_request) hold_count <= 0;
            out_ch.ready <= quiet_phase || $urandom_range(99) >= 6;
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_seen++;
            if (update_q.size() == 0) begin
                n_errors++;
                $display("[%0t] result beat with nothing expected", $time);
            end else begin
                t_update e;
                e = update_q.pop_front();
                if (out_ch.alive !== e.alive)
                    report("alive", 64'(out_ch.alive), 64'(e.alive));
                if (out_ch.new_position_xyz !== e.pos)
                    report("new_position_xyz", 64'(out_ch.new_position_xyz), 64'(e.pos));
                if (out_ch.new_velocity_xyz !== e.vel)
                    report("new_velocity_xyz", 64'(out_ch.new_velocity_xyz), 64'(e.vel));
                if (out_ch.new_spin_angle !== e.ang)
                    report("new_spin_angle", 64'(out_ch.new_spin_angle), 64'(e.ang));
                if (out_ch.new_age !== e.age)
                    report("new_age", 64'(out_ch.new_age), 64'(e.age));
                if (out_ch.new_life_left !== e.life)
                    report("new_life_left", 64'(out_ch.new_life_left), 64'(e.life));
                if (out_ch.size_valid !== e.size_valid)
                    report("size_valid", 64'(out_ch.size_valid), 64'(e.size_valid));
                if (out_ch.width !== e.width)
                    report("width", 64'(out_ch.width), 64'(e.width));
                if (out_ch.height !== e.height)
                    report("height", 64'(out_ch.height), 64'(e.height));
                if (out_ch.page !== e.page)
                    report("page", 64'(out_ch.page), 64'(e.page));
                if (out_ch.next_page !== e.next_page)
                    report("next_page", 64'(out_ch.next_page), 64'(e.next_page));
                if (out_ch.page_blend !== e.blend)
                    report("page_blend", 64'(out_ch.page_blend), 64'(e.blend));
            end
        end
    end

    // watchdog: cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("tb_particle_state_stepper NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // small-ish signed value so that sums rarely saturate
    function automatic logic [19:0] rand_q10();
        case ($urandom_range(3))
            0:       return 20'($urandom());
            default: return 20'($signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    function automatic logic [59:0] rand_vec();
        return {rand_q10(), rand_q10(), rand_q10()};
    endfunction

    function automatic t_particle rand_particle();
        t_particle p;
        p.step_time  = $urandom_range(7) == 0 ? $urandom() : $urandom_range(32'h0002_0000);
        p.age        = $urandom_range(7) == 0 ? $urandom() : $urandom_range(32'h0040_0000);
        // mostly alive, some dead
        case ($urandom_range(9))
            0:       p.life_left = $urandom();
            1:       p.life_left = -$signed($urandom_range(32'h0010_0000));
            default: p.life_left = $urandom_range(32'h0100_0000, 1);
        endcase
        p.pos  = $urandom_range(4) == 0 ? 60'(rand64()) : rand_vec();
        p.vel  = $urandom_range(4) == 0 ? 60'(rand64()) : rand_vec();
        p.ang  = rand_q10();
        p.rate = rand_q10();
        p.size_range = rand64();
        return p;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [59:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        // predictor follows the masked register
        case (idx)
            pss_pkg::CFG_SIZE_MODE:  m_size_mode  = val[2:0];
            pss_pkg::CFG_GRAVITY:    exp_gravity  = val;
            pss_pkg::CFG_SIZE_CYCLE: m_cycle_time = val[31:0];
            pss_pkg::CFG_PAGE_COUNT: m_page_count = val[7:0];
            pss_pkg::CFG_PAGE_TIME:  m_page_time  = val[31:0];
            default: ;
        endcase
    endtask

    // wait until every pending beat has come back, plus pipe depth
    task automatic drain();
        while (particle_q.size() > 0 || in_ch.valid || update_q.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic push_random(int n);
        repeat (n) particle_q.push_back(rand_particle());
    endtask

    // one configuration phase with random registers
    task automatic random_setting(logic [2:0] mode);
        write_reg(pss_pkg::CFG_SIZE_MODE, 60'(mode));
        write_reg(pss_pkg::CFG_GRAVITY, $urandom_range(2) == 0 ? 60'(rand64()) : rand_vec());
        write_reg(pss_pkg::CFG_SIZE_CYCLE, $urandom_range(3) == 0 ? 60'($urandom())
                                                        : 60'($urandom_range(32'h0008_0000)));
        write_reg(pss_pkg::CFG_PAGE_COUNT, 60'(8'($urandom())));
        write_reg(pss_pkg::CFG_PAGE_TIME, $urandom_range(3) == 0 ? 60'($urandom())
                                                       : 60'($urandom_range(32'h0004_0000)));
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin
        t_particle p;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = pss_pkg::CFG_SIZE_MODE;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.step_time = '0; in_ch.age = '0; in_ch.life_left = '0;
        in_ch.position_xyz = '0; in_ch.velocity_xyz = '0;
        in_ch.spin_angle = '0; in_ch.spin_rate = '0; in_ch.size_range = '0;
        out_ch.ready = 1'b0;
        n_errors = 0; n_sent = 0; n_seen = 0; n_dead = 0;
        timed_out = 1'b0; quiet_phase = 1'b0; hold_request = 1'b0;
        in_taken = 1'b0;
        idle_cycles = 0;
        m_size_mode  = pss_pkg::MODE_LINEAR;
        exp_gravity  = '0;
        m_cycle_time = pss_pkg::TIME_ONE;
        m_page_count = 8'd1;
        m_page_time  = pss_pkg::TIME_ONE;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: register defaults first, then field extremes
        p = '{step_time: 32'h0001_0000, age: 32'h0000_8000, life_left: 32'h0002_0000,
              pos: '0, vel: '0, ang: '0, rate: 20'h00400, size_range: 64'h0100_0200_0100_0200};
        particle_q.push_back(p);
        p.life_left = '0;                        // dead at zero life
        particle_q.push_back(p);
        p.life_left = 32'h8000_0000;             // most negative life
        p.pos = '1; p.vel = '1; p.ang = 20'h80000;
        particle_q.push_back(p);
        drain();

        write_reg(pss_pkg::CFG_GRAVITY, {20'h7FFFF, 20'h80000, 20'h7FFFF});
        write_reg(pss_pkg::CFG_SIZE_CYCLE, '0);  // zero period taken as smallest step
        write_reg(pss_pkg::CFG_PAGE_COUNT, '0);  // zero page count taken as one
        write_reg(pss_pkg::CFG_PAGE_TIME, '0);
        write_reg(3'd5, '1);                     // index beyond the map, ignored
        for (int m = 0; m < 8; m++) begin
            write_reg(pss_pkg::CFG_SIZE_MODE, 60'(m)); // every mode, including the unused ones
            p = '{step_time: 32'hFFFF_FFFF, age: 32'hFFFF_FFFF, life_left: 32'h7FFF_FFFF,
                  pos: {20'h7FFFF, 20'h80000, 20'h7FFFF}, vel: {20'h80000, 20'h7FFFF, 20'h80000},
                  ang: 20'h7FFFF, rate: 20'h7FFFF, size_range: 64'h7FFF_8000_7FFF_7FFF};
            particle_q.push_back(p);
            p.step_time = '0; p.age = '0; p.life_left = 32'd1;
            p.ang = 20'h80000; p.rate = 20'h80000; p.size_range = 64'h8000_8000_8000_8000;
            particle_q.push_back(p);
            drain();
        end

        write_reg(pss_pkg::CFG_PAGE_COUNT, 60'(8'hFF));
        write_reg(pss_pkg::CFG_PAGE_TIME, 60'(32'hFFFF_FFFF));
        write_reg(pss_pkg::CFG_SIZE_CYCLE, 60'(32'hFFFF_FFFF));
        write_reg(pss_pkg::CFG_GRAVITY, '0);
        write_reg(pss_pkg::CFG_SIZE_MODE, 60'(pss_pkg::MODE_PULSE));
        push_random(6);
        drain();

        // random phases over all modes; the second includes a long hold-off
        // on the result side and the third runs without idling
        for (int ph = 0; ph < 9; ph++) begin
            random_setting(ph == 8 ? 3'($urandom_range(7, 5)) : 3'(ph % 5));
            quiet_phase = (ph == 2);
            push_random(100);
            if (ph == 1) begin
                hold_request = 1'b1;
                wait (hold_count >= HOLD_CYCLES);
                hold_request = 1'b0;
            end
            drain();
            quiet_phase = 1'b0;
        end
        push_random(50);
        drain();

        if (timed_out) begin
            // the watchdog has already ended the run
        end
        $display("covered %0d beats (%0d dead, %0d results checked)", n_sent, n_dead, n_seen);
        $display("alive beats per size mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
        if (n_errors == 0 && update_q.size() == 0) begin
            $display("tb_particle_state_stepper OK");
        end else begin
            $display("tb_particle_state_stepper NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/pss_pkg.sv
hdl/pss_in_if.sv
hdl/pss_out_if.sv
hdl/particle_state_stepper.sv
tb/tb_particle_state_stepper.sv
